[hdl/moc_pkg.sv]
`timescale 1ns / 1ps

package moc_pkg;

  localparam int MATRIX_SIZE  = 4;
  localparam int ELEMENT_BITS = 16;

  localparam int CELL_COUNT = MATRIX_SIZE * MATRIX_SIZE;
  localparam int IDX_W      = (MATRIX_SIZE > 1) ? $clog2(MATRIX_SIZE) : 1;
  localparam int ADDR_W     = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int IN_W       = 16;
  localparam int OUT_IDX_W  = 3;
  localparam int PRODUCT_W  = 35;
  localparam int MUL_W      = 2 * ELEMENT_BITS;

  typedef struct packed {
    logic valid;
    logic first;
  } mac_ctl_t;

endpackage

[hdl/moc_ram.sv]
`timescale 1ns / 1ps

module moc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/moc_mac.sv]
`timescale 1ns / 1ps

module moc_mac (
  input  logic                                     clk,
  input  logic                                     rst,
  input  moc_pkg::mac_ctl_t                        ctl,
  input  logic signed [moc_pkg::ELEMENT_BITS-1:0]  a,
  input  logic signed [moc_pkg::ELEMENT_BITS-1:0]  b,
  output logic signed [moc_pkg::PRODUCT_W-1:0]     acc,
  output logic                                     busy
);

  logic signed [moc_pkg::MUL_W-1:0]     prod;
  moc_pkg::mac_ctl_t                    prod_ctl;
  logic signed [moc_pkg::PRODUCT_W-1:0] prod_ext;

  assign prod_ext = moc_pkg::PRODUCT_W'(prod);
  assign busy     = prod_ctl.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_ctl <= '0;
    end else begin
      prod_ctl <= ctl;
    end
  end

  always_ff @(posedge clk) begin
    prod <= a * b;
    if (prod_ctl.valid) begin
      if (prod_ctl.first) begin
        acc <= prod_ext;
      end else begin
        acc <= acc + prod_ext;
      end
    end
  end

endmodule

[hdl/matrix_orthogonality_check_core.sv]
`timescale 1ns / 1ps
// Matrix orthogonality check: computes P = A * transpose(A) for a square signed
// matrix A and reports whether P is the identity.
// The input channel (in_valid, in_ready, element_value) takes the elements of A
// one per item in row-major order, one item per cycle while loading.
// After the last element the block stops taking items and computes the N*N
// entries of P on one shared multiply-accumulate unit fed by two copies of
// the element memory; each entry is formed from N reads that pass through
// the read, product and accumulator registers into the output register.
// Results leave on the output channel (out_valid, out_ready) in row-major
// order with row_index and col_index; last_of_run marks the final entry and
// is_orthogonal is meaningful only there. If the receiver stalls, the next
// entry waits until the output register is free; nothing is dropped.
// Loading of the next matrix starts once the last entry has entered the
// output register, even while it still waits to be taken.
// Reset clears the element count and the control state; the memory contents
// need no reset because each matrix is fully written before it is read.

module matrix_orthogonality_check_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [moc_pkg::IN_W-1:0]       element_value,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [moc_pkg::PRODUCT_W-1:0]  product_value,
  output logic [moc_pkg::OUT_IDX_W-1:0]         row_index,
  output logic [moc_pkg::OUT_IDX_W-1:0]         col_index,
  output logic                                  is_orthogonal,
  output logic                                  last_of_run
);

  localparam logic [1:0] ST_LOAD  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  localparam logic [moc_pkg::IDX_W-1:0]  IDX_LAST  = moc_pkg::IDX_W'(moc_pkg::MATRIX_SIZE - 1);
  localparam logic [moc_pkg::ADDR_W-1:0] ADDR_LAST = moc_pkg::ADDR_W'(moc_pkg::CELL_COUNT - 1);

  logic [1:0]                           state;
  logic [moc_pkg::ADDR_W-1:0]           load_count;
  logic [moc_pkg::IDX_W-1:0]            row;
  logic [moc_pkg::IDX_W-1:0]            col;
  logic [moc_pkg::IDX_W-1:0]            step;
  logic                                 identity;
  moc_pkg::mac_ctl_t                    rd_ctl;
  logic                                 in_fire;
  logic                                 emit;
  logic                                 entry_last;
  logic                                 entry_ok;
  logic [moc_pkg::ADDR_W-1:0]           raddr_a;
  logic [moc_pkg::ADDR_W-1:0]           raddr_b;
  logic [moc_pkg::ELEMENT_BITS-1:0]     rdata_a;
  logic [moc_pkg::ELEMENT_BITS-1:0]     rdata_b;
  logic signed [moc_pkg::PRODUCT_W-1:0] acc;
  logic signed [moc_pkg::PRODUCT_W-1:0] expected;
  logic                                 mac_busy;

  assign in_ready = (state == ST_LOAD);
  assign in_fire  = in_valid && in_ready;

  assign raddr_a = moc_pkg::ADDR_W'(row * moc_pkg::MATRIX_SIZE + step);
  assign raddr_b = moc_pkg::ADDR_W'(col * moc_pkg::MATRIX_SIZE + step);

  assign emit       = (state == ST_DRAIN) && !rd_ctl.valid && !mac_busy &&
                      (!out_valid || out_ready);
  assign entry_last = (row == IDX_LAST) && (col == IDX_LAST);
  assign expected   = (row == col) ? moc_pkg::PRODUCT_W'(1) : '0;
  assign entry_ok   = (acc == expected);

  moc_ram #(
    .WIDTH (moc_pkg::ELEMENT_BITS),
    .DEPTH (moc_pkg::CELL_COUNT)
  ) u_ram_a (
    .clk   (clk),
    .we    (in_fire),
    .waddr (load_count),
    .wdata (element_value[moc_pkg::ELEMENT_BITS-1:0]),
    .raddr (raddr_a),
    .rdata (rdata_a)
  );

  moc_ram #(
    .WIDTH (moc_pkg::ELEMENT_BITS),
    .DEPTH (moc_pkg::CELL_COUNT)
  ) u_ram_b (
    .clk   (clk),
    .we    (in_fire),
    .waddr (load_count),
    .wdata (element_value[moc_pkg::ELEMENT_BITS-1:0]),
    .raddr (raddr_b),
    .rdata (rdata_b)
  );

  moc_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctl  (rd_ctl),
    .a    ($signed(rdata_a)),
    .b    ($signed(rdata_b)),
    .acc  (acc),
    .busy (mac_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      load_count <= '0;
      row        <= '0;
      col        <= '0;
      step       <= '0;
      identity   <= 1'b1;
      rd_ctl     <= '0;
      out_valid  <= 1'b0;
    end else begin
      rd_ctl <= '0;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end
      unique case (state)
        ST_LOAD: begin
          if (in_fire) begin
            if (load_count == ADDR_LAST) begin
              load_count <= '0;
              row        <= '0;
              col        <= '0;
              step       <= '0;
              identity   <= 1'b1;
              state      <= ST_ISSUE;
            end else begin
              load_count <= load_count + 1'b1;
            end
          end
        end
        ST_ISSUE: begin
          rd_ctl.valid <= 1'b1;
          rd_ctl.first <= (step == '0);
          if (step == IDX_LAST) begin
            step  <= '0;
            state <= ST_DRAIN;
          end else begin
            step <= step + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (emit) begin
            identity <= identity && entry_ok;
            if (entry_last) begin
              state <= ST_LOAD;
            end else begin
              state <= ST_ISSUE;
              if (col == IDX_LAST) begin
                col <= '0;
                row <= row + 1'b1;
              end else begin
                col <= col + 1'b1;
              end
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      product_value <= acc;
      row_index     <= moc_pkg::OUT_IDX_W'(row);
      col_index     <= moc_pkg::OUT_IDX_W'(col);
      is_orthogonal <= entry_last && identity && entry_ok;
      last_of_run   <= entry_last;
    end
  end

endmodule

[tb/tb_matrix_orthogonality_check_core.sv]
`timescale 1ns / 1ps

module tb_matrix_orthogonality_check_core;

  localparam int IDLE_LIMIT     = 5000;
  localparam int MISMATCH_SHOWN = 10;
  localparam int SETTLE_CYCLES  = 50;

  typedef logic signed [moc_pkg::IN_W-1:0] matrix_t [moc_pkg::CELL_COUNT];

  typedef struct {
    logic signed [moc_pkg::PRODUCT_W-1:0] value;
    logic [moc_pkg::OUT_IDX_W-1:0]        row;
    logic [moc_pkg::OUT_IDX_W-1:0]        col;
    logic                                 orthogonal;
    logic                                 last;
  } gram_entry_t;

  logic                                 clk = 1'b0;
  logic                                 rst = 1'b1;
  logic                                 in_valid = 1'b0;
  logic                                 in_ready;
  logic signed [moc_pkg::IN_W-1:0]      element_value = '0;
  logic                                 out_valid;
  logic                                 out_ready = 1'b0;
  logic signed [moc_pkg::PRODUCT_W-1:0] product_value;
  logic [moc_pkg::OUT_IDX_W-1:0]        row_index;
  logic [moc_pkg::OUT_IDX_W-1:0]        col_index;
  logic                                 is_orthogonal;
  logic                                 last_of_run;

  gram_entry_t                             pending_entries[$];
  logic signed [moc_pkg::ELEMENT_BITS-1:0] held_elements [moc_pkg::CELL_COUNT];
  int                                      elements_held = 0;
  int                                      error_count = 0;
  int                                      idle_cycles = 0;
  int                                      ready_hold = 0;
  bit                                      no_idle = 1'b0;

  matrix_orthogonality_check_core dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .element_value (element_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .product_value (product_value),
    .row_index     (row_index),
    .col_index     (col_index),
    .is_orthogonal (is_orthogonal),
    .last_of_run   (last_of_run)
  );

  always #4 clk = ~clk;

  function automatic int pick_gap();
    int roll;
    if (no_idle) return 0;
    roll = $urandom_range(99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Stores one element and, once the matrix is complete, queues every entry
  // of A times its transpose in row-major order.
  function automatic void absorb_element(logic signed [moc_pkg::IN_W-1:0] raw);
    longint      acc;
    bit          identity;
    gram_entry_t entry;
    held_elements[elements_held] = raw[moc_pkg::ELEMENT_BITS-1:0];
    elements_held++;
    if (elements_held < moc_pkg::CELL_COUNT) return;
    elements_held = 0;
    identity = 1'b1;
    for (int r = 0; r < moc_pkg::MATRIX_SIZE; r++) begin
      for (int c = 0; c < moc_pkg::MATRIX_SIZE; c++) begin
        acc = 0;
        for (int k = 0; k < moc_pkg::MATRIX_SIZE; k++) begin
          acc += longint'(held_elements[r * moc_pkg::MATRIX_SIZE + k]) *
                 longint'(held_elements[c * moc_pkg::MATRIX_SIZE + k]);
        end
        if (acc != ((r == c) ? 1 : 0)) identity = 1'b0;
        entry.value      = acc[moc_pkg::PRODUCT_W-1:0];
        entry.row        = r[moc_pkg::OUT_IDX_W-1:0];
        entry.col        = c[moc_pkg::OUT_IDX_W-1:0];
        entry.orthogonal = 1'b0;
        entry.last       = 1'b0;
        pending_entries.push_back(entry);
      end
    end
    pending_entries[$].orthogonal = identity;
    pending_entries[$].last       = 1'b1;
  endfunction

  function automatic void check_entry();
    gram_entry_t want;
    if (pending_entries.size() == 0) begin
      error_count++;
      if (error_count <= MISMATCH_SHOWN) begin
        $display("unexpected result: row %0d col %0d value %0d orth %0b last %0b",
                 row_index, col_index, product_value, is_orthogonal, last_of_run);
      end
      return;
    end
    want = pending_entries.pop_front();
    if (product_value !== want.value || row_index !== want.row ||
        col_index !== want.col || is_orthogonal !== want.orthogonal ||
        last_of_run !== want.last) begin
      error_count++;
      if (error_count <= MISMATCH_SHOWN) begin
        $display("mismatch: expected row %0d col %0d value %0d orth %0b last %0b",
                 want.row, want.col, want.value, want.orthogonal, want.last);
        $display("          got      row %0d col %0d value %0d orth %0b last %0b",
                 row_index, col_index, product_value, is_orthogonal, last_of_run);
      end
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) check_entry();
    if (ready_hold > 0) begin
      ready_hold--;
      out_ready <= 1'b0;
    end else begin
      ready_hold = pick_gap();
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_element(input logic signed [moc_pkg::IN_W-1:0] value);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    element_value <= value;
    do @(posedge clk); while (!in_ready);
    absorb_element(value);
  endtask

  task automatic send_matrix(input matrix_t m);
    for (int i = 0; i < moc_pkg::CELL_COUNT; i++) send_element(m[i]);
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_entries.size() != 0) @(posedge clk);
  endtask

  function automatic matrix_t signed_permutation();
    matrix_t m;
    int      order [moc_pkg::MATRIX_SIZE];
    int      j;
    int      t;
    foreach (m[i]) m[i] = '0;
    foreach (order[i]) order[i] = i;
    for (int i = moc_pkg::MATRIX_SIZE - 1; i > 0; i--) begin
      j = $urandom_range(i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (int r = 0; r < moc_pkg::MATRIX_SIZE; r++) begin
      m[r * moc_pkg::MATRIX_SIZE + order[r]] =
          moc_pkg::IN_W'($urandom_range(1) ? 1 : -1);
    end
    return m;
  endfunction

  function automatic matrix_t random_matrix(int style);
    matrix_t m;
    int      pick;
    foreach (m[i]) begin
      case (style)
        0: begin
          m[i] = moc_pkg::IN_W'($urandom);
        end
        1: begin
          m[i] = moc_pkg::IN_W'($urandom_range(6) - 3);
        end
        default: begin
          pick = $urandom_range(4);
          m[i] = moc_pkg::IN_W'((pick == 0) ? -32768 : (pick == 1) ? 32767 :
                                (pick == 2) ? -1 : (pick == 3) ? 1 : 0);
        end
      endcase
    end
    return m;
  endfunction

  task automatic test_identity();
    matrix_t m;
    foreach (m[i]) m[i] = '0;
    for (int r = 0; r < moc_pkg::MATRIX_SIZE; r++) begin
      m[r * moc_pkg::MATRIX_SIZE + r] = moc_pkg::IN_W'(1);
    end
    send_matrix(m);
  endtask

  // Rows of the most negative and most positive elements give the largest
  // products; the last row is zero.
  task automatic test_extremes();
    matrix_t m;
    for (int c = 0; c < moc_pkg::MATRIX_SIZE; c++) begin
      m[c]                            = moc_pkg::IN_W'(-32768);
      m[moc_pkg::MATRIX_SIZE + c]     = moc_pkg::IN_W'(32767);
      m[2 * moc_pkg::MATRIX_SIZE + c] = moc_pkg::IN_W'((c % 2) ? -32768 : 32767);
      m[3 * moc_pkg::MATRIX_SIZE + c] = '0;
    end
    send_matrix(m);
  endtask

  task automatic test_signed_permutations();
    matrix_t m;
    int      pos;
    for (int n = 0; n < 8; n++) begin
      no_idle = (n < 4);
      m = signed_permutation();
      if ($urandom_range(1)) begin
        pos = $urandom_range(moc_pkg::CELL_COUNT - 1);
        m[pos] = moc_pkg::IN_W'(m[pos] + ($urandom_range(1) ? 1 : -1) *
                                $urandom_range(1, 2));
      end
      send_matrix(m);
    end
    no_idle = 1'b0;
  endtask

  task automatic test_drain_between_matrices();
    for (int n = 0; n < 2; n++) begin
      send_matrix(random_matrix(1));
      wait_for_drain();
    end
  endtask

  task automatic test_random_matrices();
    for (int n = 0; n < 14; n++) send_matrix(random_matrix($urandom_range(2)));
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_identity();
    test_extremes();
    test_signed_permutations();
    test_drain_between_matrices();
    test_random_matrices();
    in_valid <= 1'b0;
    while (pending_entries.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
